// ===== rtl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants of the escaped frame decoder: framing bytes,
// result kinds and the result record.
// ----------------------------------------------------------------------------
package efd_pkg;

	localparam int MAX_FRAME_DEF = 512;

	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_ESC     = 8'hDB;
	localparam logic [7:0] BYTE_ESC_END = 8'hDC;
	localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;
	localparam logic [7:0] SUM_GOOD     = 8'hFF;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BADSUM   = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [8:0] position;
		logic [9:0] frame_length;
	} res_t;

endpackage

// ===== rtl/efd_rx_if.sv =====
// ----------------------------------------------------------------------------
// efd_rx_if
// Valid/ready channel carrying one raw received byte per transaction.
// ----------------------------------------------------------------------------
interface efd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/efd_res_if.sv =====
// ----------------------------------------------------------------------------
// efd_res_if
// Valid/ready channel carrying one decoder result per transaction.
// ----------------------------------------------------------------------------
interface efd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [8:0] position;
	logic [9:0] frame_length;

	modport source (output valid, output kind, output data_byte, output position,
		output frame_length, input ready);
	modport sink (input valid, input kind, input data_byte, input position,
		input frame_length, output ready);
endinterface

// ===== rtl/efd_decode.sv =====
// ----------------------------------------------------------------------------
// efd_decode
// Input register and frame state: unescapes the registered byte, keeps the
// running sum and byte count, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module efd_decode
	import efd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	output logic       res_valid,
	output res_t       res,
	input  logic       res_ready
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          esc_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    sum_q;

	logic          esc_d;
	logic [CW-1:0] cnt_d;
	logic [7:0]    sum_d;
	logic          has_res;
	logic          advance;
	logic [7:0]    decoded;
	logic [CW+9:0] cnt_ext;

	assign cnt_ext = {10'd0, cnt_q};

	always_comb begin
		decoded = byte_s1;
		if (esc_q && byte_s1 == BYTE_ESC_END) begin
			decoded = BYTE_END;
		end else if (esc_q && byte_s1 == BYTE_ESC_ESC) begin
			decoded = BYTE_ESC;
		end
	end

	always_comb begin
		esc_d   = esc_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		has_res = 1'b0;
		res     = '0;
		if (byte_s1 == BYTE_END) begin
			// leading frame end of an empty frame gives nothing
			has_res          = (cnt_q != '0) || esc_q;
			res.kind         = (sum_q == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
			res.frame_length = cnt_ext[9:0];
			esc_d            = 1'b0;
			cnt_d            = '0;
			sum_d            = '0;
		end else if (byte_s1 == BYTE_ESC) begin
			esc_d = 1'b1;
		end else if (cnt_q == MAX_CNT) begin
			has_res          = 1'b1;
			res.kind         = KIND_OVERFLOW;
			res.frame_length = cnt_ext[9:0];
			esc_d            = 1'b0;
			cnt_d            = '0;
			sum_d            = '0;
		end else begin
			has_res       = 1'b1;
			res.kind      = KIND_DATA;
			res.data_byte = decoded;
			res.position  = cnt_ext[8:0];
			esc_d         = 1'b0;
			cnt_d         = cnt_q + 1'b1;
			sum_d         = sum_q + decoded;
		end
	end

	assign advance   = valid_s1 && (!has_res || res_ready);
	assign in_ready  = !valid_s1 || advance;
	assign res_valid = valid_s1 && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			esc_q    <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				esc_q <= esc_d;
				cnt_q <= cnt_d;
				sum_q <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== rtl/efd_skid.sv =====
// ----------------------------------------------------------------------------
// efd_skid
// Result register with a skid entry, so the decoder can pass on one more
// result while a finished result waits on the output channel.
// ----------------------------------------------------------------------------
module efd_skid
	import efd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_t      push_res,
	output logic      push_ready,
	efd_res_if.source dec
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic load;

	assign push_ready = !skid_valid_q;
	assign load       = !out_valid_q || dec.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign dec.valid        = out_valid_q;
	assign dec.kind         = out_q.kind;
	assign dec.data_byte    = out_q.data_byte;
	assign dec.position     = out_q.position;
	assign dec.frame_length = out_q.frame_length;

endmodule

// ===== rtl/escaped_frame_decoder_with_sum.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_decoder_with_sum
// Escape-framed byte stream decoder with an additive frame checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction on rx and gives at most one result
// per byte on dec: each decoded payload byte with its position, and at a
// frame end (0xC0) either a good-frame report (8-bit byte sum equal to 0xFF)
// or a bad-sum drop, both with the frame length; a byte past MAX_FRAME gives
// an overflow drop. A byte is accepted every cycle when dec is not stalled;
// a result passes through the input register, then the result register,
// before it is on dec, and a stall on dec can hold it between them. Escape
// bytes and the frame end of an empty frame give no result. A two-entry result
// buffer keeps rx ready during a stall on dec while its skid entry is free.
// ----------------------------------------------------------------------------
module escaped_frame_decoder_with_sum
	import efd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	efd_rx_if.sink  rx,
	efd_res_if.source dec
);

	logic res_valid;
	logic res_ready;
	res_t res;

	efd_decode #(
		.MAX_FRAME(MAX_FRAME)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx.ready),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready)
	);

	efd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid && res_ready),
		.push_res  (res),
		.push_ready(res_ready),
		.dec       (dec)
	);

	// input side only stalls once both result entries are full
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> dec.valid)
		else $error("rx stalled while no result is pending");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.kind != KIND_DATA |-> dec.data_byte == 8'd0 && dec.position == 9'd0)
		else $error("frame end result carries data fields");

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.kind == KIND_DATA |-> dec.frame_length == 10'd0)
		else $error("data result carries a frame length");

endmodule
